// ----- hw/rtl/cpu_alu_with_flags_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// Clocked implication, disabled while reset is asserted.
`define ALU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ALU_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/alu_flg_pkg.sv -----
package alu_flg_pkg;

	// Opcodes carried in req_type
	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_INC  = 5'd2;
	localparam logic [4:0] OP_DEC  = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd5;
	localparam logic [4:0] OP_XOR  = 5'd6;
	localparam logic [4:0] OP_NOT  = 5'd7;
	localparam logic [4:0] OP_SHL  = 5'd8;
	localparam logic [4:0] OP_SAR  = 5'd9;
	localparam logic [4:0] OP_SHR  = 5'd10;
	localparam logic [4:0] OP_ROL  = 5'd11;
	localparam logic [4:0] OP_ROR  = 5'd12;
	localparam logic [4:0] OP_SWAP = 5'd13;
	localparam logic [4:0] OP_BIT  = 5'd14;
	localparam logic [4:0] OP_SET  = 5'd15;
	localparam logic [4:0] OP_RES  = 5'd16;
	localparam logic [4:0] OP_TOG  = 5'd17;

	// Width codes
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_32 = 2'd2;

	// Flag bit positions
	localparam int FLAG_Z = 7;
	localparam int FLAG_N = 6;
	localparam int FLAG_H = 5;
	localparam int FLAG_C = 4;
	localparam int FLAG_V = 3;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [1:0]  width_sel;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [7:0]  bit_index;
		logic        with_carry;
		logic        clear_zero;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] result;
		logic [7:0]  flags;
		logic        error;
	} alu_rsp_t;

endpackage

// ----- hw/rtl/cpu_alu_with_flags.sv -----
// ALU with status flags register (Z7 N6 H5 C4 V3, bits 2..0 preserved).
// Input channel: in_valid / in_stall with req_type, width_sel, operand_a,
// operand_b, bit_index, with_carry, clear_zero. An item is taken at a clock
// edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with result, flags_out, error; one
// result per item, in order.
// An accepted item passes from the input register to the output register
// and is then shown on the output. Throughput: one item per cycle while
// out_stall is low, set by the flags register, which each item reads and rewrites.
// The input register and the output register part the two sides: a new item
// is taken while a finished result waits. When out_stall holds the output,
// the input register fills and then in_stall rises; nothing is dropped.
// flags_out is the flags register itself and stays put while stalled.
// Reset (arst_n low) clears both valid bits and the flags register to zero.
module cpu_alu_with_flags
	import alu_flg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  req_type,
	input  logic [1:0]  width_sel,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic [7:0]  bit_index,
	input  logic        with_carry,
	input  logic        clear_zero,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result,
	output logic [7:0]  flags_out,
	output logic        error
);

	alu_req_t    req_s1;
	logic        valid_s1;
	alu_rsp_t    rsp;
	logic        out_valid_q;
	logic [31:0] result_q;
	logic [7:0]  flags_q;
	logic        error_q;
	logic        adv;
	logic        accept;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	alu_flg_core u_core (
		.req       (req_s1),
		.flags_cur (flags_q),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv) out_valid_q <= valid_s1;
			if (adv && valid_s1) flags_q <= rsp.flags;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{req_type: req_type, width_sel: width_sel,
				operand_a: operand_a, operand_b: operand_b, bit_index: bit_index,
				with_carry: with_carry, clear_zero: clear_zero};
		end
		if (adv && valid_s1) begin
			result_q <= rsp.result;
			error_q  <= rsp.error;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign flags_out = flags_q;
	assign error     = error_q;

endmodule

// ----- hw/rtl/alu_flg_core.sv -----
module alu_flg_core
	import alu_flg_pkg::*;
(
	input  alu_req_t   req,
	input  logic [7:0] flags_cur,
	output alu_rsp_t   rsp
);

	logic [1:0]  w;
	logic [31:0] m, hm, sm;
	logic        cin, ci, rot_in;
	logic [32:0] x, y, sum, dif;
	logic [28:0] hx, hy, hsum, hdif;
	logic [31:0] add_r, sub_r, inc_r, dec_r, swp_r;
	logic        c_add, c_sub, h_add, h_sub, v_add, v_sub;
	logic [7:0]  a8, b8, and_r, or_r, xor_r, sh_r;
	logic        sh_co, is_rot, bi_bad, sel_bit;
	logic [7:0]  bmask;
	logic [31:0] r;
	logic [7:0]  nf;
	logic        err;

	assign w = (req.width_sel == WIDTH_8) ? WIDTH_8 :
		(req.width_sel == WIDTH_16) ? WIDTH_16 : WIDTH_32;

	always_comb begin
		unique case (w)
			WIDTH_8: begin
				m = 32'h0000_00FF; hm = 32'h0000_000F; sm = 32'h0000_0080;
			end
			WIDTH_16: begin
				m = 32'h0000_FFFF; hm = 32'h0000_0FFF; sm = 32'h0000_8000;
			end
			default: begin
				m = 32'hFFFF_FFFF; hm = 32'h0FFF_FFFF; sm = 32'h8000_0000;
			end
		endcase
	end

	assign cin = flags_cur[FLAG_C];
	// carry/borrow in only for the 8-bit forms
	assign ci  = (w == WIDTH_8) && req.with_carry && cin;

	assign x    = {1'b0, req.operand_a & m};
	assign y    = {1'b0, req.operand_b & m};
	assign sum  = x + y + {32'd0, ci};
	assign dif  = x - y - {32'd0, ci};
	assign hx   = {1'b0, req.operand_a[27:0] & hm[27:0]};
	assign hy   = {1'b0, req.operand_b[27:0] & hm[27:0]};
	assign hsum = hx + hy + {28'd0, ci};
	assign hdif = hx - hy - {28'd0, ci};

	assign add_r = sum[31:0] & m;
	assign sub_r = dif[31:0] & m;

	always_comb begin
		unique case (w)
			WIDTH_8: begin
				c_add = sum[8];  c_sub = dif[8];  h_add = hsum[4];  h_sub = hdif[4];
			end
			WIDTH_16: begin
				c_add = sum[16]; c_sub = dif[16]; h_add = hsum[12]; h_sub = hdif[12];
			end
			default: begin
				c_add = sum[32]; c_sub = dif[32]; h_add = hsum[28]; h_sub = hdif[28];
			end
		endcase
	end

	assign v_add = |((x[31:0] ^ add_r) & (y[31:0] ^ add_r) & sm);
	assign v_sub = |((x[31:0] ^ y[31:0]) & (x[31:0] ^ sub_r) & sm);

	assign inc_r = (x[31:0] + 32'd1) & m;
	assign dec_r = (x[31:0] - 32'd1) & m;

	always_comb begin
		unique case (w)
			WIDTH_8:  swp_r = {24'd0, x[3:0], x[7:4]};
			WIDTH_16: swp_r = {16'd0, x[7:0], x[15:8]};
			default:  swp_r = {x[15:0], x[31:16]};
		endcase
	end

	assign a8    = req.operand_a[7:0];
	assign b8    = req.operand_b[7:0];
	assign and_r = a8 & b8;
	assign or_r  = a8 | b8;
	assign xor_r = a8 ^ b8;

	assign is_rot = (req.req_type == OP_ROL) || (req.req_type == OP_ROR);
	assign rot_in = req.with_carry ? cin :
		((req.req_type == OP_ROL) ? a8[7] : a8[0]);

	always_comb begin
		sh_r  = {a8[6:0], 1'b0};
		sh_co = a8[7];
		if (req.req_type == OP_SAR) begin
			sh_r  = {a8[7], a8[7:1]};
			sh_co = a8[0];
		end else if (req.req_type == OP_SHR) begin
			sh_r  = {1'b0, a8[7:1]};
			sh_co = a8[0];
		end else if (req.req_type == OP_ROL) begin
			sh_r  = {a8[6:0], rot_in};
			sh_co = a8[7];
		end else if (req.req_type == OP_ROR) begin
			sh_r  = {rot_in, a8[7:1]};
			sh_co = a8[0];
		end
	end

	assign bi_bad  = |req.bit_index[7:3];
	assign bmask   = 8'd1 << req.bit_index[2:0];
	assign sel_bit = |(a8 & bmask);

	always_comb begin
		r   = '0;
		nf  = flags_cur;
		err = 1'b0;
		case (req.req_type)
			OP_ADD: begin
				r  = add_r;
				nf = {add_r == 32'd0, 1'b0, h_add, c_add, v_add, flags_cur[2:0]};
			end
			OP_SUB: begin
				r  = sub_r;
				nf = {sub_r == 32'd0, 1'b1, h_sub, c_sub, v_sub, flags_cur[2:0]};
			end
			OP_INC: begin
				r  = inc_r;
				nf = {inc_r == 32'd0, 1'b0, (inc_r & hm) == 32'd0, flags_cur[FLAG_C],
					(w == WIDTH_8) ? (x[7:0] == 8'h7F) : flags_cur[FLAG_V],
					flags_cur[2:0]};
			end
			OP_DEC: begin
				r  = dec_r;
				nf = {dec_r == 32'd0, 1'b1, (x[31:0] & hm) == 32'd0, flags_cur[FLAG_C],
					(w == WIDTH_8) ? (x[7:0] == 8'h80) : flags_cur[FLAG_V],
					flags_cur[2:0]};
			end
			OP_AND: begin
				r  = {24'd0, and_r};
				nf = {and_r == 8'd0, 1'b0, 1'b1, 2'b00, flags_cur[2:0]};
			end
			OP_OR: begin
				r  = {24'd0, or_r};
				nf = {or_r == 8'd0, 4'b0000, flags_cur[2:0]};
			end
			OP_XOR: begin
				r  = {24'd0, xor_r};
				nf = {xor_r == 8'd0, 4'b0000, flags_cur[2:0]};
			end
			OP_NOT: begin
				r  = {24'd0, ~a8};
				nf = {flags_cur[FLAG_Z], 2'b11, flags_cur[FLAG_C], 1'b0, flags_cur[2:0]};
			end
			OP_SHL, OP_SAR, OP_SHR, OP_ROL, OP_ROR: begin
				r  = {24'd0, sh_r};
				nf = {(sh_r == 8'd0) && !(is_rot && req.clear_zero), 2'b00, sh_co,
					flags_cur[FLAG_V], flags_cur[2:0]};
			end
			OP_SWAP: begin
				r  = swp_r;
				nf = {swp_r == 32'd0, 3'b000, flags_cur[FLAG_V], flags_cur[2:0]};
			end
			OP_BIT: begin
				if (bi_bad) begin
					err = 1'b1;
				end else begin
					nf = {~sel_bit, 1'b0, 1'b1, flags_cur[4:0]};
				end
			end
			OP_SET, OP_RES, OP_TOG: begin
				if (bi_bad) begin
					err = 1'b1;
				end else if (req.req_type == OP_SET) begin
					r = {24'd0, a8 | bmask};
				end else if (req.req_type == OP_RES) begin
					r = {24'd0, a8 & ~bmask};
				end else begin
					r = {24'd0, a8 ^ bmask};
				end
			end
			default: begin
				// unused opcodes: no operation
				r = '0;
			end
		endcase
	end

	assign rsp.result = r;
	assign rsp.flags  = nf;
	assign rsp.error  = err;

endmodule

// ----- hw/rtl/alu_flg_checker.sv -----
`include "cpu_alu_with_flags_defines.svh"

module alu_flg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [4:0]  req_type,
	input logic [1:0]  width_sel,
	input logic [31:0] operand_a,
	input logic [31:0] operand_b,
	input logic [7:0]  bit_index,
	input logic        with_carry,
	input logic        clear_zero,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result,
	input logic [7:0]  flags_out,
	input logic        error
);

	// a held result keeps its payload
	`ALU_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(result) && $stable(flags_out) && $stable(error), "stalled result changed")

	// low flag bits start at zero and are never written
	`ALU_NEVER(a_flags_low, clk, arst_n, out_valid && (flags_out[2:0] != 3'b000), "reserved flag bits set")

	// a bad bit index gives a zero result
	`ALU_NEVER(a_err_result, clk, arst_n, out_valid && error && (result != 32'd0), "error with nonzero result")

	// an accepted item has a result on the output after the input and output registers
	`ALU_ASSERT(a_latency, clk, arst_n, in_valid && !in_stall |-> ##2 out_valid, "result missing after accept")

endmodule

bind cpu_alu_with_flags alu_flg_checker u_alu_flg_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import alu_flg_pkg::*;

	localparam logic [1:0] WIDTH_ALIAS_32 = 2'd3;
	localparam logic [4:0] OP_UNDEF_LO    = 5'd18;
	localparam logic [4:0] OP_UNDEF_HI    = 5'd31;
	localparam int         N_RANDOM       = 1500;
	localparam int         IDLE_LIMIT     = 2000;

	typedef struct {
		alu_req_t    req;
		int unsigned gap;
		bit          hold_drain;
	} op_slot_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [4:0]  req_type   = '0;
	logic [1:0]  width_sel  = '0;
	logic [31:0] operand_a  = '0;
	logic [31:0] operand_b  = '0;
	logic [7:0]  bit_index  = '0;
	logic        with_carry = 1'b0;
	logic        clear_zero = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] result;
	logic [7:0]  flags_out;
	logic        error;

	op_slot_t    op_pending_q[$];
	alu_rsp_t    rsp_expect_q[$];
	op_slot_t    drv_slot;
	alu_req_t    drv_req;
	alu_rsp_t    drv_rsp;
	alu_rsp_t    want;
	logic [7:0]  flag_state  = '0;
	int unsigned gap_cnt     = 0;
	int unsigned stall_cnt   = 0;
	int          n_issued    = 0;
	int          n_total     = 0;
	int          n_fail      = 0;
	int          idle_cycles = 0;
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;

	cpu_alu_with_flags u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.width_sel  (width_sel),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.bit_index  (bit_index),
		.with_carry (with_carry),
		.clear_zero (clear_zero),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.flags_out  (flags_out),
		.error      (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected result and next flags for one item, given the flags before it.
	function automatic alu_rsp_t alu_predict(input alu_req_t q, input logic [7:0] f);
		logic [1:0]  w;
		logic [31:0] m, hm, sm, x, y, r;
		logic [32:0] s, hs;
		logic [7:0]  a8, b8, nf;
		logic        ci, co, fill, err;
		alu_rsp_t    rsp;
		w = (q.width_sel == WIDTH_ALIAS_32) ? WIDTH_32 : q.width_sel;
		case (w)
			WIDTH_8: begin
				m = 32'hFF; hm = 32'h0F; sm = 32'h80;
			end
			WIDTH_16: begin
				m = 32'hFFFF; hm = 32'h0FFF; sm = 32'h8000;
			end
			default: begin
				m = 32'hFFFF_FFFF; hm = 32'h0FFF_FFFF; sm = 32'h8000_0000;
			end
		endcase
		a8 = q.operand_a[7:0];
		b8 = q.operand_b[7:0];
		x = q.operand_a & m;
		y = q.operand_b & m;
		r = '0;
		nf = f;
		err = 1'b0;
		co = 1'b0;
		// carry/borrow in only for the 8-bit forms
		ci = (w == WIDTH_8) && q.with_carry && f[FLAG_C];
		case (q.req_type)
			OP_ADD: begin
				s = {1'b0, x} + {1'b0, y} + ci;
				hs = {1'b0, q.operand_a & hm} + {1'b0, q.operand_b & hm} + ci;
				r = s[31:0] & m;
				nf = f & 8'h07;
				nf[FLAG_H] = hs > {1'b0, hm};
				nf[FLAG_C] = s > {1'b0, m};
				nf[FLAG_V] = |((x ^ r) & (y ^ r) & sm);
				nf[FLAG_Z] = (r == 0);
			end
			OP_SUB: begin
				r = (x - y - ci) & m;
				s = {1'b0, y} + ci;
				hs = {1'b0, q.operand_b & hm} + ci;
				nf = f & 8'h07;
				nf[FLAG_N] = 1'b1;
				nf[FLAG_H] = {1'b0, q.operand_a & hm} < hs;
				nf[FLAG_C] = {1'b0, x} < s;
				nf[FLAG_V] = |((x ^ y) & (x ^ r) & sm);
				nf[FLAG_Z] = (r == 0);
			end
			OP_INC, OP_DEC: begin
				nf = f & ((w == WIDTH_8) ? 8'h17 : 8'h1F);
				if (q.req_type == OP_INC) begin
					r = (x + 1) & m;
					nf[FLAG_H] = ((r & hm) == 0);
					if (w == WIDTH_8 && x == 32'h7F)
						nf[FLAG_V] = 1'b1;
				end else begin
					r = (x - 1) & m;
					nf[FLAG_N] = 1'b1;
					nf[FLAG_H] = ((x & hm) == 0);
					if (w == WIDTH_8 && x == 32'h80)
						nf[FLAG_V] = 1'b1;
				end
				nf[FLAG_Z] = (r == 0);
			end
			OP_AND, OP_OR, OP_XOR: begin
				case (q.req_type)
					OP_AND:  r = {24'b0, a8 & b8};
					OP_OR:   r = {24'b0, a8 | b8};
					default: r = {24'b0, a8 ^ b8};
				endcase
				nf = f & 8'h07;
				nf[FLAG_H] = (q.req_type == OP_AND);
				nf[FLAG_Z] = (r == 0);
			end
			OP_NOT: begin
				r = {24'b0, ~a8};
				nf = f & 8'h97;
				nf[FLAG_N] = 1'b1;
				nf[FLAG_H] = 1'b1;
			end
			OP_SHL, OP_SAR, OP_SHR, OP_ROL, OP_ROR: begin
				case (q.req_type)
					OP_SHL: begin
						co = a8[7];
						r = {24'b0, a8[6:0], 1'b0};
					end
					OP_SAR: begin
						co = a8[0];
						r = {24'b0, a8[7], a8[7:1]};
					end
					OP_SHR: begin
						co = a8[0];
						r = {25'b0, a8[7:1]};
					end
					OP_ROL: begin
						co = a8[7];
						fill = q.with_carry ? f[FLAG_C] : co;
						r = {24'b0, a8[6:0], fill};
					end
					default: begin
						co = a8[0];
						fill = q.with_carry ? f[FLAG_C] : co;
						r = {24'b0, fill, a8[7:1]};
					end
				endcase
				nf = f & 8'h0F;
				nf[FLAG_Z] = (r == 0) &&
					!((q.req_type == OP_ROL || q.req_type == OP_ROR) && q.clear_zero);
				nf[FLAG_C] = co;
			end
			OP_SWAP: begin
				case (w)
					WIDTH_8:  r = {24'b0, x[3:0], x[7:4]};
					WIDTH_16: r = {16'b0, x[7:0], x[15:8]};
					default:  r = {x[15:0], x[31:16]};
				endcase
				nf = f & 8'h0F;
				nf[FLAG_Z] = (r == 0);
			end
			OP_BIT, OP_SET, OP_RES, OP_TOG: begin
				if (q.bit_index >= 8) begin
					err = 1'b1;
				end else begin
					case (q.req_type)
						OP_BIT: begin
							nf = f & 8'h1F;
							nf[FLAG_H] = 1'b1;
							nf[FLAG_Z] = !a8[q.bit_index[2:0]];
						end
						OP_SET:  r = {24'b0, a8 | (8'h01 << q.bit_index[2:0])};
						OP_RES:  r = {24'b0, a8 & ~(8'h01 << q.bit_index[2:0])};
						default: r = {24'b0, a8 ^ (8'h01 << q.bit_index[2:0])};
					endcase
				end
			end
			default: ;
		endcase
		rsp.result = r;
		rsp.flags = nf;
		rsp.error = err;
		return rsp;
	endfunction

	task automatic push_op(input logic [4:0] op, input logic [1:0] w,
			input logic [31:0] a, input logic [31:0] b, input logic [7:0] bi,
			input logic wc, input logic cz, input bit drain);
		op_slot_t slot;
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		slot.req.req_type = op;
		slot.req.width_sel = w;
		slot.req.operand_a = a;
		slot.req.operand_b = b;
		slot.req.bit_index = bi;
		slot.req.with_carry = wc;
		slot.req.clear_zero = cz;
		slot.gap = tx_calm ? 0 : $urandom_range(0, 3);
		slot.hold_drain = drain;
		op_pending_q.push_back(slot);
	endtask

	// operands biased toward sign, carry and half-carry boundaries
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7F + $urandom_range(0, 1);
			3: return 32'h7FFF + $urandom_range(0, 1);
			4: return 32'h7FFF_FFFF + $urandom_range(0, 1);
			5: return 32'h0F + $urandom_range(0, 1) * 32'h10;
			6: return $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_cnt = 0;
		end else begin
			if (in_valid && !in_stall) begin
				drv_rsp = alu_predict(drv_req, flag_state);
				flag_state = drv_rsp.flags;
				rsp_expect_q.push_back(drv_rsp);
				n_issued++;
			end
			if (!in_valid || !in_stall) begin
				if (op_pending_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_cnt < op_pending_q[0].gap) begin
					gap_cnt++;
					in_valid <= 1'b0;
				end else if (op_pending_q[0].hold_drain && rsp_expect_q.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					drv_slot = op_pending_q.pop_front();
					drv_req = drv_slot.req;
					gap_cnt = 0;
					in_valid <= 1'b1;
					req_type <= drv_req.req_type;
					width_sel <= drv_req.width_sel;
					operand_a <= drv_req.operand_a;
					operand_b <= drv_req.operand_b;
					bit_index <= drv_req.bit_index;
					with_carry <= drv_req.with_carry;
					clear_zero <= drv_req.clear_zero;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rsp_expect_q.size() == 0) begin
					$error("unexpected item: result %h flags %h error %b",
						result, flags_out, error);
					n_fail++;
				end else begin
					want = rsp_expect_q.pop_front();
					if (result !== want.result) begin
						$error("result: expected %h, got %h", want.result, result);
						n_fail++;
					end
					if (flags_out !== want.flags) begin
						$error("flags_out: expected %h, got %h", want.flags, flags_out);
						n_fail++;
					end
					if (error !== want.error) begin
						$error("error: expected %b, got %b", want.error, error);
						n_fail++;
					end
				end
				stall_cnt = rx_calm ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 99) == 0)
					rx_calm = !rx_calm;
			end
			if (stall_cnt > 0) begin
				out_stall <= 1'b1;
				stall_cnt--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** cpu_alu_with_flags: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [4:0] op;
		// directed: flag corners of each operation
		push_op(OP_ADD,  WIDTH_8,  32'hFF, 32'h01, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_ADD,  WIDTH_8,  32'h0E, 32'h01, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_ADD,  WIDTH_8,  32'h7F, 32'h01, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_ADD,  WIDTH_16, 32'hFFFF, 32'h1, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_ADD,  WIDTH_ALIAS_32, 32'h7FFF_FFFF, 32'h1, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_SUB,  WIDTH_8,  32'h00, 32'h01, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_SUB,  WIDTH_8,  32'h10, 32'h0F, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_SUB,  WIDTH_32, 32'h8000_0000, 32'h1, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_INC,  WIDTH_8,  32'h7F, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_INC,  WIDTH_16, 32'hFFFF, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_DEC,  WIDTH_8,  32'h80, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_DEC,  WIDTH_32, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0, 1'b1);
		push_op(OP_AND,  WIDTH_8,  32'hF0, 32'h0F, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_OR,   WIDTH_16, 32'hFF00, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_XOR,  WIDTH_8,  32'hA5, 32'h1A5, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_NOT,  WIDTH_8,  32'hFFFF_FF00, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_SHL,  WIDTH_8,  32'h80, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_SAR,  WIDTH_8,  32'h81, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_SHR,  WIDTH_8,  32'h01, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_ROL,  WIDTH_8,  32'h80, 32'h0, 8'd0, 1'b0, 1'b1, 1'b0);
		push_op(OP_ROL,  WIDTH_8,  32'h00, 32'h0, 8'd0, 1'b1, 1'b1, 1'b0);
		push_op(OP_ROR,  WIDTH_8,  32'h01, 32'h0, 8'd0, 1'b1, 1'b0, 1'b0);
		push_op(OP_SWAP, WIDTH_8,  32'hF0, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_SWAP, WIDTH_ALIAS_32, 32'h1234_5678, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);
		push_op(OP_BIT,  WIDTH_8,  32'h7F, 32'h0, 8'd7, 1'b0, 1'b0, 1'b0);
		push_op(OP_SET,  WIDTH_8,  32'h00, 32'h0, 8'd8, 1'b0, 1'b0, 1'b0);
		push_op(OP_RES,  WIDTH_8,  32'hFF, 32'h0, 8'd3, 1'b0, 1'b0, 1'b0);
		push_op(OP_TOG,  WIDTH_8,  32'h55, 32'h0, 8'd255, 1'b0, 1'b0, 1'b0);
		push_op(OP_UNDEF_LO, WIDTH_16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0);
		push_op(OP_UNDEF_HI, WIDTH_8, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 19) == 0)
				op = 5'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
			else
				op = 5'($urandom_range(OP_ADD, OP_TOG));
			push_op(op, 2'($urandom_range(0, 3)), rand_word(), rand_word(),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
				1'($urandom), 1'($urandom), (i % 250) == 249);
		end
		n_total = op_pending_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (n_issued < n_total)
			@(posedge clk);
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (n_fail == 0)
			$display("** cpu_alu_with_flags: PASSED **");
		else
			$display("** cpu_alu_with_flags: FAILED **");
		$finish;
	end

endmodule
